// File: rtl/ddjm_pkg.sv
// ddjm_pkg: shared constants and types for the differential drive joystick mixer
// used by the channel interfaces, the divider pipeline and the top level
// no dependencies
`default_nettype none

package ddjm_pkg;

  // field widths of the channels
  localparam int StickW  = 12;
  localparam int RegW    = 10;
  localparam int DriveW  = 11;
  localparam int CfgIdxW = 2;

  // default number of fraction bits on the stick inputs
  localparam int StickFracBits = 10;

  // register reset values
  localparam logic [RegW-1:0] DriveRangeReset = 10'd1023;
  localparam logic [RegW-1:0] PivotLimitReset = 10'd32;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    RegDriveRange = 2'd0,
    RegPivotLimit = 2'd1
  } cfg_reg_e;

  // divider shape: quotient bits, bits resolved per stage, stage count
  localparam int QBits    = DriveW - 1;
  localparam int StepBits = 2;
  localparam int DivSteps = QBits / StepBits;
  localparam logic [QBits-1:0] DriveMax = '1;

  // default numerator width for the default fraction bits
  localparam int DivNumW = 39;

  // lanes of the divider
  localparam int Lanes     = 2;
  localparam int LaneLeft  = 0;
  localparam int LaneRight = 1;

endpackage

`default_nettype wire

// File: rtl/ddjm_if.sv
// ddjm_if: valid/ready channel interfaces for sticks, drive commands and config writes
// depends on ddjm_pkg for field widths
`default_nettype none

// joystick sample channel
interface ddjm_stick_if import ddjm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [StickW-1:0] x_stick;
  logic signed [StickW-1:0] y_stick;

  modport source (output valid, output x_stick, output y_stick, input ready);
  modport sink   (input valid, input x_stick, input y_stick, output ready);
endinterface

// motor command channel
interface ddjm_drive_if import ddjm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DriveW-1:0] left_drive;
  logic signed [DriveW-1:0] right_drive;

  modport source (output valid, output left_drive, output right_drive, input ready);
  modport sink   (input valid, input left_drive, input right_drive, output ready);
endinterface

// register write channel
interface ddjm_cfg_if import ddjm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [RegW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/ddjm_div.sv
// ddjm_div: pipelined signed divide of two numerators by a shared positive divisor
// truncates toward zero and saturates to the drive range; depends on ddjm_pkg, ddjm_if
`default_nettype none

module ddjm_div import ddjm_pkg::*; #(
  parameter int NUM_W = DivNumW
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    num_valid_i,
  output logic                    num_ready_o,
  input  logic signed [NUM_W-1:0] num_left_i,
  input  logic signed [NUM_W-1:0] num_right_i,
  input  logic [2*RegW-1:0]       den_i,
  ddjm_drive_if.source            drive_o
);

  // stages: magnitude, overflow check, quotient steps, output register
  localparam int DS = DivSteps + 2;
  localparam int NS = DivSteps + 3;

  logic [NS-1:0]    v_q;
  logic [NS-1:0]    en;
  logic [NUM_W-1:0] rem_q [DS][Lanes];
  logic [QBits-1:0] quo_q [DS][Lanes];
  logic [Lanes-1:0] neg_q [DS];
  logic [Lanes-1:0] ovf_q [DS];
  logic signed [NUM_W-1:0]  num_in [Lanes];
  logic [NUM_W-1:0]         den_w;
  logic signed [DriveW-1:0] drv_d [Lanes];
  logic signed [DriveW-1:0] drv_q [Lanes];

  assign num_in[LaneLeft]  = num_left_i;
  assign num_in[LaneRight] = num_right_i;
  assign den_w = NUM_W'(den_i);

  // stage enables: a stage loads when it is empty or its contents move on
  always_comb begin
    en[NS-1] = !v_q[NS-1] || drive_o.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign num_ready_o = en[0];

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= num_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // magnitude and sign of each numerator
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int ln = 0; ln < Lanes; ln++) begin
        neg_q[0][ln] <= num_in[ln][NUM_W-1];
        rem_q[0][ln] <= num_in[ln][NUM_W-1] ? NUM_W'(-num_in[ln]) : NUM_W'(num_in[ln]);
        quo_q[0][ln] <= '0;
        ovf_q[0][ln] <= 1'b0;
      end
    end
  end

  // quotient above full scale saturates
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int ln = 0; ln < Lanes; ln++) begin
        neg_q[1][ln] <= neg_q[0][ln];
        rem_q[1][ln] <= rem_q[0][ln];
        quo_q[1][ln] <= '0;
        ovf_q[1][ln] <= (rem_q[0][ln] >= (den_w << QBits));
      end
    end
  end

  // restoring division, StepBits quotient bits per stage
  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    for (genvar ln = 0; ln < Lanes; ln++) begin : g_lane
      logic [NUM_W-1:0] rem_d;
      logic [QBits-1:0] quo_d;

      always_comb begin
        logic [NUM_W-1:0] sh;
        int               bi;
        rem_d = rem_q[k+1][ln];
        quo_d = quo_q[k+1][ln];
        for (int j = 0; j < StepBits; j++) begin
          bi = QBits - 1 - (k * StepBits + j);
          sh = den_w << bi;
          if (rem_d >= sh) begin
            rem_d     = rem_d - sh;
            quo_d[bi] = 1'b1;
          end
        end
      end

      always_ff @(posedge clk_i) begin
        if (en[k+2]) begin
          rem_q[k+2][ln] <= rem_d;
          quo_q[k+2][ln] <= quo_d;
          neg_q[k+2][ln] <= neg_q[k+1][ln];
          ovf_q[k+2][ln] <= ovf_q[k+1][ln];
        end
      end
    end
  end

  // saturate and restore the sign
  always_comb begin
    logic [QBits-1:0] mag;
    for (int ln = 0; ln < Lanes; ln++) begin
      mag = ovf_q[DS-1][ln] ? DriveMax : quo_q[DS-1][ln];
      drv_d[ln] = neg_q[DS-1][ln] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      drv_q <= drv_d;
    end
  end

  assign drive_o.valid       = v_q[NS-1];
  assign drive_o.left_drive  = drv_q[LaneLeft];
  assign drive_o.right_drive = drv_q[LaneRight];

  // the final left remainder is below the divisor unless saturated
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[DS-1] && !ovf_q[DS-1][LaneLeft] |-> rem_q[DS-1][LaneLeft] < den_w)
    else $error("left remainder not reduced below divisor");

  // divisor is never zero while stage 1 holds an item
  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> den_i != '0)
    else $error("zero divisor reached the divider");

  // back pressure only when every stage is full and the sink stalls
  a_full_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !num_ready_o |-> (&v_q) && !drive_o.ready)
    else $error("divider stalled with an empty stage");

endmodule

`default_nettype wire

// File: rtl/differential_drive_joystick_mixer.sv
// differential_drive_joystick_mixer: top level, stick scaling, quadrant premix and pivot blend
// depends on ddjm_pkg, ddjm_if and ddjm_div
//
//   channel  | dir | payload                    | transaction
//   stick_i  | in  | x_stick, y_stick (s12)     | one joystick sample
//   drive_o  | out | left_drive, right_drive    | one motor command pair (s11)
//   cfg_i    | in  | index (2b), data (10b)     | one register write, always ready
//
// one sample enters per cycle while the pipeline is not stalled; its result reaches drive_o
// through six mixing and eight divider register stages, the first loaded when it is taken
// the divider resolves two quotient bits per stage against pivot_limit * drive_range
// reset clears all valid bits and loads drive_range = 1023, pivot_limit = 32
// each stage moves on when the next one is empty or moving, so a stalled output
// holds its result while earlier stages keep filling
`default_nettype none

module differential_drive_joystick_mixer import ddjm_pkg::*; #(
  parameter int STICK_FRAC_BITS = StickFracBits
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ddjm_stick_if.sink   stick_i,
  ddjm_drive_if.source drive_o,
  ddjm_cfg_if.sink     cfg_i
);

  // datapath widths
  localparam int ProdW = StickW + RegW + 1;
  localparam int XW    = ProdW - STICK_FRAC_BITS;
  localparam int PW    = ((XW > RegW + 1) ? XW : RegW + 1) + 1;
  localparam int MW    = (XW > RegW) ? XW : RegW;
  localparam int M1W   = RegW + 1 + PW;
  localparam int M2W   = RegW + 1 + XW;
  localparam int T1W   = M1W + XW;
  localparam int T2W   = M2W + RegW + 1;
  localparam int NW    = ((T1W > T2W) ? T1W : T2W) + 1;
  localparam int FS    = 6;
  localparam logic [DriveW-1:0] DriveNegFull = {1'b1, {(DriveW-1){1'b0}}};

  // configuration registers
  logic [RegW-1:0]   drive_range_q, pivot_limit_q;
  logic [RegW-1:0]   range_eff, lim_eff;
  logic [2*RegW-1:0] den_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_range_q <= DriveRangeReset;
      pivot_limit_q <= PivotLimitReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegDriveRange: drive_range_q <= cfg_i.data;
        RegPivotLimit: pivot_limit_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // zero registers act as one
  assign range_eff = (drive_range_q == '0) ? RegW'(1) : drive_range_q;
  assign lim_eff   = (pivot_limit_q == '0) ? RegW'(1) : pivot_limit_q;

  // shared divisor
  always_ff @(posedge clk_i) begin
    den_q <= (2*RegW)'(range_eff) * (2*RegW)'(lim_eff);
  end

  // front pipeline control
  logic [FS-1:0] v_q;
  logic [FS-1:0] en;
  logic          div_ready;

  always_comb begin
    en[FS-1] = !v_q[FS-1] || div_ready;
    for (int k = FS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign stick_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= stick_i.valid;
      end
      for (int k = 1; k < FS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // stage 0: sticks times range
  logic signed [ProdW-1:0] px_q, py_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      px_q <= ProdW'(stick_i.x_stick) * $signed(ProdW'(range_eff));
      py_q <= ProdW'(stick_i.y_stick) * $signed(ProdW'(range_eff));
    end
  end

  // stage 1: round to nearest, ties away from zero
  logic [ProdW-1:0]     xm, ym, xs, ys;
  logic signed [XW-1:0] x1_d, y1_d, x1_q, y1_q;

  always_comb begin
    xm   = px_q[ProdW-1] ? ProdW'(-px_q) : ProdW'(px_q);
    ym   = py_q[ProdW-1] ? ProdW'(-py_q) : ProdW'(py_q);
    xs   = xm + (ProdW'(1) << (STICK_FRAC_BITS - 1));
    ys   = ym + (ProdW'(1) << (STICK_FRAC_BITS - 1));
    x1_d = px_q[ProdW-1] ? -$signed(xs[ProdW-1:STICK_FRAC_BITS])
                         : $signed(xs[ProdW-1:STICK_FRAC_BITS]);
    y1_d = py_q[ProdW-1] ? -$signed(ys[ProdW-1:STICK_FRAC_BITS])
                         : $signed(ys[ProdW-1:STICK_FRAC_BITS]);
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      x1_q <= x1_d;
      y1_q <= y1_d;
    end
  end

  // stage 2: quadrant premix and throttle clamp
  logic signed [PW-1:0] rng_p, x_p, pl_d, pr_d, pl_q, pr_q;
  logic [XW-1:0]        y_mag;
  logic [RegW-1:0]      a_d, a_q, b_q;
  logic signed [XW-1:0] x2_q, y2_q;

  always_comb begin
    rng_p = $signed(PW'(range_eff));
    x_p   = PW'(x1_q);
    if (!y1_q[XW-1]) begin
      pl_d = x1_q[XW-1] ? rng_p + x_p : rng_p;
      pr_d = x1_q[XW-1] ? rng_p : rng_p - x_p;
    end else begin
      pl_d = x1_q[XW-1] ? rng_p : rng_p - x_p;
      pr_d = x1_q[XW-1] ? rng_p + x_p : rng_p;
    end
    y_mag = y1_q[XW-1] ? XW'(-y1_q) : XW'(y1_q);
    a_d   = (MW'(y_mag) > MW'(lim_eff)) ? lim_eff : RegW'(y_mag);
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      pl_q <= pl_d;
      pr_q <= pr_d;
      a_q  <= a_d;
      b_q  <= lim_eff - a_d;
      x2_q <= x1_q;
      y2_q <= y1_q;
    end
  end

  // stage 3: first products
  logic signed [M1W-1:0] m1l_q, m1r_q;
  logic signed [M2W-1:0] m2_q;
  logic signed [XW-1:0]  y3_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      m1l_q <= M1W'($signed({1'b0, a_q})) * M1W'(pl_q);
      m1r_q <= M1W'($signed({1'b0, a_q})) * M1W'(pr_q);
      m2_q  <= M2W'($signed({1'b0, b_q})) * M2W'(x2_q);
      y3_q  <= y2_q;
    end
  end

  // stage 4: throttle and pivot terms
  logic signed [T1W-1:0] t1r_q, t1l_q;
  logic signed [T2W-1:0] t2_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      t1r_q <= T1W'(m1l_q) * T1W'(y3_q);
      t1l_q <= T1W'(m1r_q) * T1W'(y3_q);
      t2_q  <= T2W'(m2_q) * $signed(T2W'(range_eff));
    end
  end

  // stage 5: numerators, left premix feeds the right side
  logic signed [NW-1:0] nr_q, nl_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      nr_q <= NW'(t1r_q) + NW'(t2_q);
      nl_q <= NW'(t1l_q) - NW'(t2_q);
    end
  end

  // divide, truncate and saturate
  ddjm_div #(
    .NUM_W(NW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .num_valid_i (v_q[FS-1]),
    .num_ready_o (div_ready),
    .num_left_i  (nl_q),
    .num_right_i (nr_q),
    .den_i       (den_q),
    .drive_o     (drive_o)
  );

  // saturation never yields the most negative code
  a_no_neg_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drive_o.valid |-> drive_o.left_drive != DriveNegFull
                      && drive_o.right_drive != DriveNegFull)
    else $error("drive command beyond negative full scale");

  // clamped throttle stays within the pivot limit
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[2] |-> a_q <= lim_eff)
    else $error("clamped throttle above pivot limit");

  // a zero range write takes effect as one
  a_zero_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid && cfg_i.index == RegDriveRange && cfg_i.data == '0
    |=> range_eff == RegW'(1))
    else $error("zero drive range not treated as one");

endmodule

`default_nettype wire
